### hdl/pds_pkg.sv
`timescale 1ns / 1ps
// pds_pkg: shared types, constants and arithmetic step functions for the
// pixel depth statistics pipeline; no dependencies
package pds_pkg;

    // pipeline geometry
    localparam int DIV_STEPS  = 12;  // mean dividers, 2 quotient bits per stage
    localparam int QDIV_STEPS = 24;  // sum / n divider, 2 quotient bits per stage
    localparam int SQRT_STEPS = 12;  // 24-bit root, 2 root bits per stage
    localparam int WB_DEPTH   = DIV_STEPS + 5;  // stages holding an unwritten update
    localparam int INFL_W     = $clog2(WB_DEPTH + 1);

    // register map, selected by paddr[2]
    localparam logic REG_TARGET   = 1'b0;
    localparam logic REG_CAMPAIGN = 1'b1;

    localparam logic [15:0] CAMPAIGN_RESET = 16'd100;
    localparam logic [15:0] FRAME_MAX      = 16'hFFFF;
    localparam logic [23:0] STD_MAX        = 24'hFFFFFF;

    // per-item control carried down the pipe
    typedef struct packed {
        logic [15:0] n;      // frame number
        logic        last;   // last pixel of frame
        logic        done;   // campaign frame
        logic        first;  // frame one
        logic [15:0] depth;
    } t_tag;

    // one restoring division step: returns {quotient bit, remainder}
    function automatic logic [16:0] div_bit(input logic [15:0] rem, input logic b,
                                            input logic [15:0] d);
        logic [16:0] t;
        t = {rem, b};
        if (t >= {1'b0, d}) begin
            div_bit = {1'b1, 16'(t - {1'b0, d})};
        end else begin
            div_bit = {1'b0, t[15:0]};
        end
    endfunction

    // one digit-by-digit square root step: returns {remainder, root}
    function automatic logic [49:0] sqrt_bit(input logic [25:0] rem, input logic [1:0] pair,
                                             input logic [23:0] root);
        logic [27:0] t;
        logic [27:0] trial;
        t     = {rem, pair};
        trial = {2'b00, root, 2'b01};
        if (t >= trial) begin
            sqrt_bit = {26'(t - trial), root[22:0], 1'b1};
        end else begin
            sqrt_bit = {t[25:0], root[22:0], 1'b0};
        end
    endfunction

endpackage

### hdl/pixel_depth_statistics.sv
`timescale 1ns / 1ps
// pixel_depth_statistics: per-pixel running mean, std deviation and mean error
// over a stream of depth frames; depends on pds_pkg
//
// usage
//   slave stream: one depth sample (mm) per transfer, row major, NUM_PIXELS per
//   frame; the pixel and frame position are counted internally from reset
//   master stream: one result per sample; tdata holds pixel index, frame
//   number, mean, std and mean error (mm, 8 fractional bits), tlast marks the
//   last pixel of a frame and tuser flags the frame number equal to the
//   campaign length register
//   apb port: register 0 target distance, register 1 campaign length
// timing
//   one sample is taken every cycle unless one of the stalls below holds the
//   input. the per-pixel update is written back 17 stages after entry, so
//   with NUM_PIXELS of 17 or fewer input waits until the previous
//   update of the same pixel is stored. the whole pipe moves under one enable:
//   when the receiver holds tready low with a result waiting, every stage holds
//   and tready on the slave side drops, nothing is lost or repeated
// reset
//   synchronous, active low; clears valid bits, the pixel and frame counters and
//   the registers. the per-pixel stores are not cleared: frame one seeds them
module pixel_depth_statistics #(
    parameter int NUM_PIXELS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [15:0] depth_mm
    // master stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [95:0] o_m_tdata,   // [5:0] pixel_index, [21:6] frame_number,
                                     // [45:22] mean_depth, [69:46] std_depth,
                                     // [93:70] abs_err_mean, [95:94] zero
    output logic        o_m_tlast,   // frame_last
    output logic        o_m_tuser,   // campaign_done
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int PIX_W = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;
    localparam int DS = pds_pkg::DIV_STEPS;
    localparam int QS = pds_pkg::QDIV_STEPS;
    localparam int SS = pds_pkg::SQRT_STEPS;
    localparam int IW = pds_pkg::INFL_W;

    // ---------------- configuration registers ----------------
    logic [15:0] r_target;
    logic [15:0] r_campaign;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target   <= 16'd0;
            r_campaign <= pds_pkg::CAMPAIGN_RESET;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[2])
                pds_pkg::REG_TARGET:   r_target   <= pwdata[15:0];
                pds_pkg::REG_CAMPAIGN: r_campaign <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            pds_pkg::REG_TARGET:   prdata = {16'd0, r_target};
            pds_pkg::REG_CAMPAIGN: prdata = {16'd0, r_campaign};
            default:               prdata = 32'd0;
        endcase
    end

    // ---------------- flow control ----------------
    logic                      adv;      // global pipe enable
    logic                      acc;      // input transfer
    logic                      wb;       // update written back this edge
    logic [IW-1:0]             r_infl;   // items not yet written back
    logic                      r_o_vld;
    logic                      r_f_vld;

    assign adv        = !r_o_vld || i_m_tready;
    assign o_s_tready = adv && (int'(r_infl) < NUM_PIXELS);
    assign acc        = i_s_tvalid && o_s_tready;
    assign wb         = adv && r_f_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_infl <= '0;
        end else begin
            case ({acc, wb})
                2'b10:   r_infl <= r_infl + IW'(1);
                2'b01:   r_infl <= r_infl - IW'(1);
                default: r_infl <= r_infl;
            endcase
        end
    end

    // ---------------- position counters ----------------
    logic [PIX_W-1:0] r_pix;
    logic [15:0]      r_frame;   // current frame number, saturating
    logic             in_last;

    assign in_last = (r_pix == PIX_W'(NUM_PIXELS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix   <= '0;
            r_frame <= 16'd1;
        end else if (acc) begin
            if (in_last) begin
                r_pix <= '0;
                if (r_frame != pds_pkg::FRAME_MAX) begin
                    r_frame <= r_frame + 16'd1;
                end
            end else begin
                r_pix <= r_pix + PIX_W'(1);
            end
        end
    end

    // ---------------- per-pixel stores ----------------
    logic [23:0] mem_mean [NUM_PIXELS];
    logic [23:0] mem_err  [NUM_PIXELS];
    logic [63:0] mem_sum  [NUM_PIXELS];

    // ---------------- stage A: entry and store read ----------------
    logic             r_a_vld;
    logic [PIX_W-1:0] r_a_pix;
    pds_pkg::t_tag    r_a_tag;
    logic [15:0]      r_a_abs;
    logic [23:0]      r_a_mm;
    logic [23:0]      r_a_me;
    logic [63:0]      r_a_ms;
    pds_pkg::t_tag    in_tag;
    logic [15:0]      in_abs;

    always_comb begin
        in_tag.n     = r_frame;
        in_tag.last  = in_last;
        in_tag.done  = (r_frame == r_campaign);
        in_tag.first = (r_frame == 16'd1);
        in_tag.depth = i_s_tdata;
        in_abs = (i_s_tdata >= r_target) ? (i_s_tdata - r_target) : (r_target - i_s_tdata);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (adv) begin
            r_a_vld <= acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_pix <= r_pix;
            r_a_tag <= in_tag;
            r_a_abs <= in_abs;
            r_a_mm  <= mem_mean[r_pix];
            r_a_me  <= mem_err[r_pix];
            r_a_ms  <= mem_sum[r_pix];
        end
    end

    // ---------------- stage B: old mean times (n - 1) ----------------
    logic             r_b_vld;
    logic [PIX_W-1:0] r_b_pix;
    pds_pkg::t_tag    r_b_tag;
    logic [15:0]      r_b_abs;
    logic [39:0]      r_b_pm;
    logic [39:0]      r_b_pe;
    logic [63:0]      r_b_sum;
    logic [23:0]      gm;
    logic [23:0]      ge;
    logic [15:0]      nm1;

    always_comb begin
        // frame one ignores what the stores hold
        gm  = r_a_tag.first ? 24'd0 : r_a_mm;
        ge  = r_a_tag.first ? 24'd0 : r_a_me;
        nm1 = r_a_tag.n - 16'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (adv) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_pix <= r_a_pix;
            r_b_tag <= r_a_tag;
            r_b_abs <= r_a_abs;
            r_b_pm  <= {16'd0, gm} * {24'd0, nm1};
            r_b_pe  <= {16'd0, ge} * {24'd0, nm1};
            r_b_sum <= r_a_tag.first ? 64'd0 : r_a_ms;
        end
    end

    // ---------------- stage C: numerators ----------------
    logic             r_c_vld;
    logic [PIX_W-1:0] r_c_pix;
    pds_pkg::t_tag    r_c_tag;
    logic [39:0]      r_c_nm;
    logic [39:0]      r_c_ne;
    logic [63:0]      r_c_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (adv) begin
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c_pix <= r_b_pix;
            r_c_tag <= r_b_tag;
            r_c_nm  <= r_b_pm + {16'd0, r_b_tag.depth, 8'd0};
            r_c_ne  <= r_b_pe + {16'd0, r_b_abs, 8'd0};
            r_c_sum <= r_b_sum;
        end
    end

    // ---------------- stages D: divide both numerators by n ----------------
    // numerator < n * 2^24, so the top 16 bits start below n
    logic             r_d_vld [DS];
    logic [PIX_W-1:0] r_d_pix [DS];
    pds_pkg::t_tag    r_d_tag [DS];
    logic [63:0]      r_d_sum [DS];
    logic [15:0]      r_d_mr  [DS];
    logic [23:0]      r_d_ml  [DS];
    logic [15:0]      r_d_er  [DS];
    logic [23:0]      r_d_el  [DS];

    for (genvar g = 0; g < DS; g++) begin : g_div
        logic             s_vld;
        logic [PIX_W-1:0] s_pix;
        pds_pkg::t_tag    s_tag;
        logic [63:0]      s_sum;
        logic [15:0]      s_mr;
        logic [23:0]      s_ml;
        logic [15:0]      s_er;
        logic [23:0]      s_el;
        logic [15:0]      n_mr;
        logic [23:0]      n_ml;
        logic [15:0]      n_er;
        logic [23:0]      n_el;

        if (g == 0) begin : g_src
            assign s_vld = r_c_vld;
            assign s_pix = r_c_pix;
            assign s_tag = r_c_tag;
            assign s_sum = r_c_sum;
            assign s_mr  = r_c_nm[39:24];
            assign s_ml  = r_c_nm[23:0];
            assign s_er  = r_c_ne[39:24];
            assign s_el  = r_c_ne[23:0];
        end else begin : g_src
            assign s_vld = r_d_vld[g-1];
            assign s_pix = r_d_pix[g-1];
            assign s_tag = r_d_tag[g-1];
            assign s_sum = r_d_sum[g-1];
            assign s_mr  = r_d_mr[g-1];
            assign s_ml  = r_d_ml[g-1];
            assign s_er  = r_d_er[g-1];
            assign s_el  = r_d_el[g-1];
        end

        always_comb begin
            logic [16:0] tm;
            logic [16:0] te;
            n_mr = s_mr;
            n_ml = s_ml;
            n_er = s_er;
            n_el = s_el;
            for (int j = 0; j < 2; j++) begin
                tm   = pds_pkg::div_bit(n_mr, n_ml[23], s_tag.n);
                n_ml = {n_ml[22:0], tm[16]};
                n_mr = tm[15:0];
                te   = pds_pkg::div_bit(n_er, n_el[23], s_tag.n);
                n_el = {n_el[22:0], te[16]};
                n_er = te[15:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d_vld[g] <= 1'b0;
            end else if (adv) begin
                r_d_vld[g] <= s_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_d_pix[g] <= s_pix;
                r_d_tag[g] <= s_tag;
                r_d_sum[g] <= s_sum;
                r_d_mr[g]  <= n_mr;
                r_d_ml[g]  <= n_ml;
                r_d_er[g]  <= n_er;
                r_d_el[g]  <= n_el;
            end
        end
    end

    // ---------------- stage E: deviation from new mean ----------------
    logic             r_e_vld;
    logic [PIX_W-1:0] r_e_pix;
    pds_pkg::t_tag    r_e_tag;
    logic [63:0]      r_e_sum;
    logic [23:0]      r_e_mean;
    logic [23:0]      r_e_err;
    logic [23:0]      r_e_dev;
    logic [23:0]      dq;
    logic [23:0]      mq;

    assign dq = {r_d_tag[DS-1].depth, 8'd0};
    assign mq = r_d_ml[DS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else if (adv) begin
            r_e_vld <= r_d_vld[DS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_e_pix  <= r_d_pix[DS-1];
            r_e_tag  <= r_d_tag[DS-1];
            r_e_sum  <= r_d_sum[DS-1];
            r_e_mean <= mq;
            r_e_err  <= r_d_el[DS-1];
            r_e_dev  <= (dq >= mq) ? (dq - mq) : (mq - dq);
        end
    end

    // ---------------- stage F: squared deviation ----------------
    logic [PIX_W-1:0] r_f_pix;
    pds_pkg::t_tag    r_f_tag;
    logic [63:0]      r_f_sum;
    logic [23:0]      r_f_mean;
    logic [23:0]      r_f_err;
    logic [47:0]      r_f_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (adv) begin
            r_f_vld <= r_e_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_f_pix  <= r_e_pix;
            r_f_tag  <= r_e_tag;
            r_f_sum  <= r_e_sum;
            r_f_mean <= r_e_mean;
            r_f_err  <= r_e_err;
            r_f_sq   <= {24'd0, r_e_dev} * {24'd0, r_e_dev};
        end
    end

    // ---------------- stage G: saturating sum and write back ----------------
    logic             r_g_vld;
    logic [PIX_W-1:0] r_g_pix;
    pds_pkg::t_tag    r_g_tag;
    logic [23:0]      r_g_mean;
    logic [23:0]      r_g_err;
    logic [63:0]      r_g_sum;
    logic [64:0]      sum_x;
    logic [63:0]      sum_new;

    always_comb begin
        sum_x = {1'b0, r_f_sum} + {17'd0, r_f_sq};
        if (r_f_tag.first) begin
            sum_new = 64'd0;
        end else if (sum_x[64]) begin
            sum_new = '1;
        end else begin
            sum_new = sum_x[63:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wb) begin
            mem_mean[r_f_pix] <= r_f_mean;
            mem_err[r_f_pix]  <= r_f_err;
            mem_sum[r_f_pix]  <= sum_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_vld <= 1'b0;
        end else if (adv) begin
            r_g_vld <= r_f_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_g_pix  <= r_f_pix;
            r_g_tag  <= r_f_tag;
            r_g_mean <= r_f_mean;
            r_g_err  <= r_f_err;
            r_g_sum  <= sum_new;
        end
    end

    // ---------------- stages Q: sum / n, 48 quotient bits ----------------
    // a quotient at or above 2^48 gives a root past the 24-bit range
    logic             r_q_vld  [QS];
    logic [PIX_W-1:0] r_q_pix  [QS];
    pds_pkg::t_tag    r_q_tag  [QS];
    logic [23:0]      r_q_mean [QS];
    logic [23:0]      r_q_err  [QS];
    logic             r_q_sat  [QS];
    logic [15:0]      r_q_rem  [QS];
    logic [47:0]      r_q_low  [QS];

    for (genvar g = 0; g < QS; g++) begin : g_qdiv
        logic             s_vld;
        logic [PIX_W-1:0] s_pix;
        pds_pkg::t_tag    s_tag;
        logic [23:0]      s_mean;
        logic [23:0]      s_err;
        logic             s_sat;
        logic [15:0]      s_rem;
        logic [47:0]      s_low;
        logic [15:0]      n_rem;
        logic [47:0]      n_low;

        if (g == 0) begin : g_src
            assign s_vld  = r_g_vld;
            assign s_pix  = r_g_pix;
            assign s_tag  = r_g_tag;
            assign s_mean = r_g_mean;
            assign s_err  = r_g_err;
            assign s_sat  = (r_g_sum[63:48] >= r_g_tag.n);
            assign s_rem  = s_sat ? 16'd0 : r_g_sum[63:48];
            assign s_low  = r_g_sum[47:0];
        end else begin : g_src
            assign s_vld  = r_q_vld[g-1];
            assign s_pix  = r_q_pix[g-1];
            assign s_tag  = r_q_tag[g-1];
            assign s_mean = r_q_mean[g-1];
            assign s_err  = r_q_err[g-1];
            assign s_sat  = r_q_sat[g-1];
            assign s_rem  = r_q_rem[g-1];
            assign s_low  = r_q_low[g-1];
        end

        always_comb begin
            logic [16:0] t;
            n_rem = s_rem;
            n_low = s_low;
            for (int j = 0; j < 2; j++) begin
                t     = pds_pkg::div_bit(n_rem, n_low[47], s_tag.n);
                n_low = {n_low[46:0], t[16]};
                n_rem = t[15:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_q_vld[g] <= 1'b0;
            end else if (adv) begin
                r_q_vld[g] <= s_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_q_pix[g]  <= s_pix;
                r_q_tag[g]  <= s_tag;
                r_q_mean[g] <= s_mean;
                r_q_err[g]  <= s_err;
                r_q_sat[g]  <= s_sat;
                r_q_rem[g]  <= n_rem;
                r_q_low[g]  <= n_low;
            end
        end
    end

    // ---------------- stages S: integer square root ----------------
    logic             r_s_vld  [SS];
    logic [PIX_W-1:0] r_s_pix  [SS];
    pds_pkg::t_tag    r_s_tag  [SS];
    logic [23:0]      r_s_mean [SS];
    logic [23:0]      r_s_err  [SS];
    logic             r_s_sat  [SS];
    logic [25:0]      r_s_rem  [SS];
    logic [23:0]      r_s_root [SS];
    logic [47:0]      r_s_qb   [SS];

    for (genvar g = 0; g < SS; g++) begin : g_sqrt
        logic             s_vld;
        logic [PIX_W-1:0] s_pix;
        pds_pkg::t_tag    s_tag;
        logic [23:0]      s_mean;
        logic [23:0]      s_err;
        logic             s_sat;
        logic [25:0]      s_rem;
        logic [23:0]      s_root;
        logic [47:0]      s_qb;
        logic [25:0]      n_rem;
        logic [23:0]      n_root;
        logic [47:0]      n_qb;

        if (g == 0) begin : g_src
            assign s_vld  = r_q_vld[QS-1];
            assign s_pix  = r_q_pix[QS-1];
            assign s_tag  = r_q_tag[QS-1];
            assign s_mean = r_q_mean[QS-1];
            assign s_err  = r_q_err[QS-1];
            assign s_sat  = r_q_sat[QS-1];
            assign s_rem  = 26'd0;
            assign s_root = 24'd0;
            assign s_qb   = r_q_low[QS-1];
        end else begin : g_src
            assign s_vld  = r_s_vld[g-1];
            assign s_pix  = r_s_pix[g-1];
            assign s_tag  = r_s_tag[g-1];
            assign s_mean = r_s_mean[g-1];
            assign s_err  = r_s_err[g-1];
            assign s_sat  = r_s_sat[g-1];
            assign s_rem  = r_s_rem[g-1];
            assign s_root = r_s_root[g-1];
            assign s_qb   = r_s_qb[g-1];
        end

        always_comb begin
            logic [49:0] t;
            n_rem  = s_rem;
            n_root = s_root;
            n_qb   = s_qb;
            for (int j = 0; j < 2; j++) begin
                t      = pds_pkg::sqrt_bit(n_rem, n_qb[47:46], n_root);
                n_rem  = t[49:24];
                n_root = t[23:0];
                n_qb   = {n_qb[45:0], 2'b00};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_s_vld[g] <= 1'b0;
            end else if (adv) begin
                r_s_vld[g] <= s_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_s_pix[g]  <= s_pix;
                r_s_tag[g]  <= s_tag;
                r_s_mean[g] <= s_mean;
                r_s_err[g]  <= s_err;
                r_s_sat[g]  <= s_sat;
                r_s_rem[g]  <= n_rem;
                r_s_root[g] <= n_root;
                r_s_qb[g]   <= n_qb;
            end
        end
    end

    // ---------------- output register ----------------
    logic [95:0] r_o_data;
    logic        r_o_last;
    logic        r_o_done;
    logic [23:0] std_fin;

    assign std_fin = r_s_sat[SS-1] ? pds_pkg::STD_MAX : r_s_root[SS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (adv) begin
            r_o_vld <= r_s_vld[SS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_o_data <= {2'b00, r_s_err[SS-1], std_fin, r_s_mean[SS-1],
                         r_s_tag[SS-1].n, 6'(r_s_pix[SS-1])};
            r_o_last <= r_s_tag[SS-1].last;
            r_o_done <= r_s_tag[SS-1].done;
        end
    end

    assign o_m_tvalid = r_o_vld;
    assign o_m_tdata  = r_o_data;
    assign o_m_tlast  = r_o_last;
    assign o_m_tuser  = r_o_done;

endmodule

### hdl/pds_checker.sv
`timescale 1ns / 1ps
// pds_checker: port-level assertions for pixel_depth_statistics, with the
// bind that attaches it; no package dependency
module pds_checker #(
    parameter int NUM_PIXELS = 64
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [95:0] o_m_tdata,
    input logic        o_m_tlast
);

    // a held result keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // nothing comes out right after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // frame one has no spread
    a_std0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[21:6] == 16'd1) |-> (o_m_tdata[69:46] == 24'd0))
        else $error("nonzero std in frame one");

    // frame end sits on the last pixel
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> (o_m_tdata[5:0] == 6'(NUM_PIXELS - 1)))
        else $error("tlast away from last pixel");

endmodule

bind pixel_depth_statistics pds_checker #(.NUM_PIXELS(NUM_PIXELS)) u_pds_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);
